>>> design/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_EQ  = 4'd4, OP_NE  = 4'd5, OP_GT  = 4'd6, OP_LT  = 4'd7,
        OP_GE  = 4'd8, OP_LE  = 4'd9, OP_MAX = 4'd10, OP_MIN = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13
    } op_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;

    // classified request handed from front to back
    typedef struct packed {
        logic        is_mul;
        logic        is_div;
        logic        neg;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] value;
        logic        cmp;
        logic [1:0]  status;
    } req_t;

endpackage

>>> design/fpa_front.sv
// Front end: decodes, computes simple ops, prepares magnitudes for mul/div.
module fpa_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [3:0]         req_type,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               req_valid,
    output fpa_pkg::req_t      req
);

    fpa_pkg::req_t     req_next;
    fpa_pkg::req_t     req_reg;
    logic              valid_reg;
    logic signed [32:0] sum;
    logic signed [32:0] dif;
    logic signed [32:0] inc;
    logic signed [32:0] dec;

    function automatic fpa_pkg::req_t sat33(input logic signed [32:0] v);
        fpa_pkg::req_t r;
        r = '0;
        if (v[32] != v[31])
        begin
            r.value  = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
            r.status = fpa_pkg::ST_SAT;
        end
        else
        begin
            r.value = v[31:0];
        end
        return r;
    endfunction

    always_comb
    begin
        sum = 33'(operand_a) + 33'(operand_b);
        dif = 33'(operand_a) - 33'(operand_b);
        inc = 33'(operand_a) + 33'sd1;
        dec = 33'(operand_a) - 33'sd1;
        req_next = '0;
        case (req_type)
            fpa_pkg::OP_ADD: req_next = sat33(sum);
            fpa_pkg::OP_SUB: req_next = sat33(dif);
            fpa_pkg::OP_INC: req_next = sat33(inc);
            fpa_pkg::OP_DEC: req_next = sat33(dec);
            fpa_pkg::OP_MUL, fpa_pkg::OP_DIV:
            begin
                req_next.is_mul = (req_type == fpa_pkg::OP_MUL);
                req_next.is_div = (req_type == fpa_pkg::OP_DIV);
                req_next.neg    = operand_a[31] ^ operand_b[31];
                req_next.mag_a  = operand_a[31] ? 32'(-operand_a) : operand_a;
                req_next.mag_b  = operand_b[31] ? 32'(-operand_b) : operand_b;
            end
            fpa_pkg::OP_EQ: req_next.cmp = (operand_a == operand_b);
            fpa_pkg::OP_NE: req_next.cmp = (operand_a != operand_b);
            fpa_pkg::OP_GT: req_next.cmp = (operand_a > operand_b);
            fpa_pkg::OP_LT: req_next.cmp = (operand_a < operand_b);
            fpa_pkg::OP_GE: req_next.cmp = (operand_a >= operand_b);
            fpa_pkg::OP_LE: req_next.cmp = (operand_a <= operand_b);
            fpa_pkg::OP_MAX: req_next.value = (operand_b > operand_a) ? operand_b : operand_a;
            fpa_pkg::OP_MIN: req_next.value = (operand_b < operand_a) ? operand_b : operand_a;
            default: req_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

>>> design/fpa_back.sv
// Back end: pipelined multiply and radix-2 divide, rounding and saturation.
module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  fpa_pkg::req_t req,
    output logic          done,
    output logic [31:0]   result_value,
    output logic          compare_true,
    output logic [1:0]    status
);

    // dividend = 2*|a|<<F + |b| fits in NW bits; quotient bits computed one per stage
    localparam int NW = 34 + FRAC_BITS;
    localparam int DW = 33;
    localparam int NS = NW;
    localparam logic [63:0] HALF = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;

    typedef struct packed {
        logic              valid;
        fpa_pkg::req_t     r;
        logic [NW-1:0]     num;
        logic [DW-1:0]     den;
        logic [DW:0]       rem;
        logic [NW-1:0]     quo;
        logic [63:0]       prod;
    } stage_t;

    stage_t pipe_reg [NS+1];
    stage_t pipe_next [NS+1];
    logic [63:0] prod_full;
    logic [63:0] mag;
    logic [64:0] q_signed;

    always_comb
    begin
        prod_full = 64'(req.mag_a) * 64'(req.mag_b);
        pipe_next[0]       = '0;
        pipe_next[0].valid = req_valid;
        pipe_next[0].r     = req;
        pipe_next[0].num   = NW'({req.mag_a, {FRAC_BITS{1'b0}}, 1'b0}) + NW'(req.mag_b);
        pipe_next[0].den   = {req.mag_b, 1'b0};
        pipe_next[0].prod  = prod_full;
        for (int i = 1; i <= NS; i++)
        begin
            pipe_next[i] = pipe_reg[i-1];
            pipe_next[i].rem = {pipe_reg[i-1].rem[DW-1:0], pipe_reg[i-1].num[NW-1]};
            pipe_next[i].num = {pipe_reg[i-1].num[NW-2:0], 1'b0};
            if (pipe_next[i].rem >= {1'b0, pipe_reg[i-1].den})
            begin
                pipe_next[i].rem = pipe_next[i].rem - {1'b0, pipe_reg[i-1].den};
                pipe_next[i].quo = {pipe_reg[i-1].quo[NW-2:0], 1'b1};
            end
            else
            begin
                pipe_next[i].quo = {pipe_reg[i-1].quo[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
                pipe_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i <= NS; i++)
                pipe_reg[i] <= pipe_next[i];
        end
    end

    // final formatting, registered
    logic [31:0] val_next;
    logic [1:0]  st_next;
    logic [31:0] val_reg;
    logic [1:0]  st_reg;
    logic        cmp_reg;
    logic        done_reg;
    stage_t      last;

    always_comb
    begin
        last = pipe_reg[NS];
        val_next = last.r.value;
        st_next  = last.r.status;
        mag      = '0;
        q_signed = '0;
        if (last.r.is_mul || last.r.is_div)
        begin
            if (last.r.is_mul)
                mag = (last.prod + HALF) >> FRAC_BITS;
            else
                mag = 64'(last.quo);
            q_signed = last.r.neg ? 65'(0) - 65'(mag) : 65'(mag);
            if (last.r.is_div && last.den == '0)
            begin
                val_next = '0;
                st_next  = fpa_pkg::ST_DIVZERO;
            end
            else if (!last.r.neg && mag > 64'h7fff_ffff)
            begin
                val_next = 32'h7fff_ffff;
                st_next  = fpa_pkg::ST_SAT;
            end
            else if (last.r.neg && mag > 64'h8000_0000)
            begin
                val_next = 32'h8000_0000;
                st_next  = fpa_pkg::ST_SAT;
            end
            else
            begin
                val_next = q_signed[31:0];
                st_next  = fpa_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        st_reg  <= st_next;
        cmp_reg <= last.r.cmp;
    end

    assign done         = done_reg;
    assign result_value = val_reg;
    assign compare_true = cmp_reg;
    assign status       = st_reg;

endmodule

>>> design/fixed_point_alu.sv
// Fixed-point ALU top level: one operation per cycle.
// The divider pipeline computes one quotient bit per stage; every op passes through it.
// Throughput: one beat accepted every cycle; busy stays low.
// Results appear with done for one cycle; the receiver cannot stall.
// Reset clears all valid flags; no result is produced until a new beat is taken.
module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         req_type,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               done,
    output logic signed [31:0] result_value,
    output logic               compare_true,
    output logic [1:0]         status
);

    logic          req_valid;
    fpa_pkg::req_t req;
    logic [31:0]   res;

    assign busy = 1'b0;

    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .req_valid (req_valid),
        .req       (req)
    );

    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req          (req),
        .done         (done),
        .result_value (res),
        .compare_true (compare_true),
        .status       (status)
    );

    assign result_value = res;

endmodule

>>> tb/fpa_checker.sv
// Result checker for the fixed-point ALU: predicts each accepted beat and compares outputs.
module fpa_checker
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [3:0]         req_type,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    input  logic               done,
    input  logic signed [31:0] result_value,
    input  logic               compare_true,
    input  logic [1:0]         status,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [31:0] value;
        logic        cmp;
        logic [1:0]  st;
    } alu_out_t;

    alu_out_t expected_q[$];

    function automatic logic [31:0] saturate(input logic signed [65:0] v, inout logic [1:0] st);
        if (v > 66'sd2147483647) begin
            st = ST_SAT;
            return 32'h7FFF_FFFF;
        end
        if (v < -66'sd2147483648) begin
            st = ST_SAT;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic alu_out_t compute_alu(input logic [3:0] op,
                                             input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        alu_out_t r;
        logic signed [65:0] wa, wb, prod;
        logic [65:0] mag, num, den, half;
        logic neg;
        wa = a;
        wb = b;
        r = '0;
        r.st = ST_OK;
        case (op)
            OP_ADD: r.value = saturate(wa + wb, r.st);
            OP_SUB: r.value = saturate(wa - wb, r.st);
            OP_MUL:
            begin
                prod = wa * wb;
                neg = prod < 0;
                mag = neg ? -prod : prod;
                half = (FRAC_BITS > 0) ? (66'd1 << (FRAC_BITS - 1)) : 66'd0;
                mag = (mag + half) >> FRAC_BITS;
                r.value = saturate(neg ? -$signed(mag) : $signed(mag), r.st);
            end
            OP_DIV:
            begin
                if (b == 0)
                    r.st = ST_DIVZERO;
                else
                begin
                    num = (wa < 0 ? -wa : wa);
                    num = num << FRAC_BITS;
                    den = (wb < 0 ? -wb : wb);
                    mag = (2 * num + den) / (2 * den);
                    neg = (a < 0) != (b < 0);
                    r.value = saturate(neg ? -$signed(mag) : $signed(mag), r.st);
                end
            end
            OP_EQ: r.cmp = a == b;
            OP_NE: r.cmp = a != b;
            OP_GT: r.cmp = a > b;
            OP_LT: r.cmp = a < b;
            OP_GE: r.cmp = a >= b;
            OP_LE: r.cmp = a <= b;
            OP_MAX: r.value = (b > a) ? b : a;
            OP_MIN: r.value = (b < a) ? b : a;
            OP_INC: r.value = saturate(wa + 1, r.st);
            OP_DEC: r.value = saturate(wa - 1, r.st);
            default: r = '0;
        endcase
        return r;
    endfunction

    int shown;
    alu_out_t want;

    assign pending = expected_q.size();

    initial
    begin
        fail_count = 0;
        shown = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // result check first: a beat taken this edge cannot come out the same edge
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("unexpected result value=%h cmp=%0d st=%0d",
                                 result_value, compare_true, status);
                    end
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.value !== result_value || want.cmp !== compare_true
                        || want.st !== status)
                    begin
                        fail_count++;
                        if (shown < 10)
                        begin
                            shown++;
                            $display("mismatch: exp value=%h cmp=%0d st=%0d got value=%h cmp=%0d st=%0d",
                                     want.value, want.cmp, want.st,
                                     result_value, compare_true, status);
                        end
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(compute_alu(req_type, operand_a, operand_b));
        end
    end

endmodule

>>> tb/testbench.sv
// Testbench top for the fixed-point ALU: reset, stimulus and verdict.
module testbench;
    import fpa_pkg::*;

    localparam int LATENCY = FRAC_BITS_DEF + 37;
    localparam int CYCLE_LIMIT = 200000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic               done;
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [1:0]         status;
    int                 fail_count;
    int                 pending;
    int                 cycles;

    fixed_point_alu i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .operand_a(operand_a), .operand_b(operand_b),
        .done(done), .result_value(result_value),
        .compare_true(compare_true), .status(status)
    );

    fpa_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .operand_a(operand_a), .operand_b(operand_b),
        .done(done), .result_value(result_value),
        .compare_true(compare_true), .status(status),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // operand with a bias toward edge values and small fixed-point numbers
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
            1: return 32'h8000_0000 + $urandom_range(0, 2);
            2: return $urandom_range(0, 4) - 2;
            3, 4: return $signed($urandom_range(0, 8191)) - 4096;
            5: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            default: return $urandom;
        endcase
    endfunction

    // hold one beat on the ports until accepted, then drop start unless the random gap is zero
    task automatic send_beat(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
        int gap;
        start <= 1'b1;
        req_type <= op;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    logic [31:0] edges[8] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h0000_0100, 32'hFFFF_FF00, 32'h5555_AAAA};
    int n;

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req_type = OP_ADD;
        operand_a = '0;
        operand_b = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int op = 0; op < 16; op++)
            send_beat(op[3:0], edges[op % 8], edges[(op * 3 + 1) % 8]);
        send_beat(OP_DIV, 32'h0000_0500, 32'h0);
        send_beat(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_beat(OP_MUL, 32'h0000_0080, 32'hFFFF_FF80);
        send_beat(OP_DIV, 32'h8000_0000, 32'h0000_0001);
        send_beat(OP_INC, 32'h7FFF_FFFF, 32'h1234_5678);
        send_beat(OP_DEC, 32'h8000_0000, 32'h0);
        send_beat(OP_LE, 32'h0000_0042, 32'h0000_0042);
        send_beat(OP_MAX, 32'h0000_0007, 32'h0000_0007);
        send_beat(OP_SUB, 32'h8000_0000, 32'h0000_0001);

        for (n = 0; n < 900; n++)
        begin
            if (n == 450)
            begin
                start <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            send_beat(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
        end
        start <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
